FILE: sv/tcf_pkg.sv
// tcf_pkg: types, constants and the ones' complement adder shared by the
// tcp/ipv4 checksum fill unit; no dependencies
package tcf_pkg;

  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] CNT_MAX      = 16'hffff;
  localparam logic [15:0] MIN_PKT_LEN  = 16'd20;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [15:0] IDX_IHL      = 16'd0;
  localparam logic [15:0] IDX_LEN_HI   = 16'd2;
  localparam logic [15:0] IDX_LEN_LO   = 16'd3;
  localparam logic [15:0] IDX_PROTO    = 16'd9;
  localparam logic [15:0] IDX_IPCS_HI  = 16'd10;
  localparam logic [15:0] IDX_IPCS_LO  = 16'd11;
  localparam logic [15:0] IDX_ADDR_LO  = 16'd12;
  localparam logic [15:0] IDX_ADDR_END = 16'd20;
  localparam logic [15:0] OFF_TCPCS_HI = 16'd16;
  localparam logic [15:0] OFF_TCPCS_LO = 16'd17;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_TCP = 2'd1,
    ST_BAD_IHL = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  // packet totals captured on the last byte
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  hdr_words;
    logic [7:0]  proto_seen;
    logic [15:0] total_len;
    logic [15:0] hdr_sum;
    logic [15:0] seg_sum;
  } snap_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: sv/tcf_ifs.sv
// tcf_in_if / tcf_out_if: valid/ready channels of the checksum fill unit
// no dependencies
interface tcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;
  modport source (output valid, output pkt_byte, output last_byte, input ready);
  modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface tcf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ip_checksum;
  logic [15:0] tcp_checksum;
  logic [1:0]  status;
  modport source (output valid, output ip_checksum, output tcp_checksum, output status,
                  input ready);
  modport sink   (input valid, input ip_checksum, input tcp_checksum, input status,
                  output ready);
endinterface

FILE: sv/tcf_accum.sv
// tcf_accum: per-byte header capture and running ones' complement sums,
// with a snapshot register loaded on the last byte; depends on tcf_pkg
module tcf_accum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_transfer,
  input  logic [7:0]    in_pkt_byte,
  input  logic          in_last_byte,
  output logic          in_ready,
  input  logic          snap_ready,
  output logic          snap_valid,
  output tcf_pkg::snap_t snap
);
  import tcf_pkg::*;

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [3:0]  hdr_words_r, hdr_words_nxt;
  logic [7:0]  proto_seen_r, proto_seen_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] hdr_sum_r, hdr_sum_nxt;
  logic [15:0] seg_sum_r, seg_sum_nxt;
  logic        snap_valid_r;
  snap_t       snap_r;

  logic [15:0] idx;
  logic [15:0] hlen;
  logic [15:0] contrib;
  logic [15:0] seg_mid;
  logic        hdr_hit;
  logic        addr_hit;
  logic        seg_hit;

  always_comb begin
    idx            = byte_count_r;
    hdr_words_nxt  = hdr_words_r;
    total_len_nxt  = total_len_r;
    proto_seen_nxt = proto_seen_r;
    if (idx == IDX_IHL) begin
      hdr_words_nxt = in_pkt_byte[3:0];
    end else if (idx == IDX_LEN_HI) begin
      total_len_nxt = {in_pkt_byte, total_len_r[7:0]};
    end else if (idx == IDX_LEN_LO) begin
      total_len_nxt = {total_len_r[15:8], in_pkt_byte};
    end else if (idx == IDX_PROTO) begin
      proto_seen_nxt = in_pkt_byte;
    end
    hlen    = {10'd0, hdr_words_nxt, 2'b00};
    contrib = idx[0] ? {8'd0, in_pkt_byte} : {in_pkt_byte, 8'd0};

    // header checksum field counts as zero
    hdr_hit  = (idx < hlen) && (idx != IDX_IPCS_HI) && (idx != IDX_IPCS_LO);
    // pseudo-header addresses
    addr_hit = (idx >= IDX_ADDR_LO) && (idx < IDX_ADDR_END);
    // segment bytes, tcp checksum field counts as zero
    seg_hit  = (idx >= hlen) && (idx < total_len_nxt) &&
               (idx != hlen + OFF_TCPCS_HI) && (idx != hlen + OFF_TCPCS_LO);

    hdr_sum_nxt    = hdr_hit ? oc_add(hdr_sum_r, contrib) : hdr_sum_r;
    seg_mid        = addr_hit ? oc_add(seg_sum_r, contrib) : seg_sum_r;
    seg_sum_nxt    = seg_hit ? oc_add(seg_mid, contrib) : seg_mid;
    byte_count_nxt = (byte_count_r == CNT_MAX) ? byte_count_r : byte_count_r + 16'd1;
  end

  // snapshot slot is free or being emptied this cycle
  assign in_ready = !snap_valid_r || snap_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      hdr_words_r  <= '0;
      proto_seen_r <= '0;
      total_len_r  <= '0;
      hdr_sum_r    <= '0;
      seg_sum_r    <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (in_transfer) begin
        if (in_last_byte) begin
          byte_count_r <= '0;
          hdr_words_r  <= '0;
          proto_seen_r <= '0;
          total_len_r  <= '0;
          hdr_sum_r    <= '0;
          seg_sum_r    <= '0;
        end else begin
          byte_count_r <= byte_count_nxt;
          hdr_words_r  <= hdr_words_nxt;
          proto_seen_r <= proto_seen_nxt;
          total_len_r  <= total_len_nxt;
          hdr_sum_r    <= hdr_sum_nxt;
          seg_sum_r    <= seg_sum_nxt;
        end
      end
      if (in_transfer && in_last_byte) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer && in_last_byte) begin
      snap_r.byte_count <= byte_count_nxt;
      snap_r.hdr_words  <= hdr_words_nxt;
      snap_r.proto_seen <= proto_seen_nxt;
      snap_r.total_len  <= total_len_nxt;
      snap_r.hdr_sum    <= hdr_sum_nxt;
      snap_r.seg_sum    <= seg_sum_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

FILE: sv/tcf_finish.sv
// tcf_finish: pseudo-header length fold, status decode and result register
// depends on tcf_pkg
module tcf_finish (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_valid,
  input  tcf_pkg::snap_t snap,
  output logic           snap_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_ip_checksum,
  output logic [15:0]    out_tcp_checksum,
  output logic [1:0]     out_status
);
  import tcf_pkg::*;

  logic        out_valid_r;
  logic [15:0] ip_cs_r, ip_cs_nxt;
  logic [15:0] tcp_cs_r, tcp_cs_nxt;
  status_t     status_r, status_nxt;

  logic        free;
  logic [15:0] hlen;
  logic [15:0] seglen;
  logic [15:0] seg_final;

  always_comb begin
    hlen      = {10'd0, snap.hdr_words, 2'b00};
    seglen    = snap.total_len - hlen;
    seg_final = oc_add(oc_add(snap.seg_sum, {8'd0, PROTO_TCP}), seglen);

    if (snap.byte_count < MIN_PKT_LEN) begin
      status_nxt = ST_TRUNC;
    end else if (snap.hdr_words < MIN_IHL) begin
      status_nxt = ST_BAD_IHL;
    end else if ((snap.byte_count < snap.total_len) || (snap.total_len < hlen)) begin
      status_nxt = ST_TRUNC;
    end else if (snap.proto_seen != PROTO_TCP) begin
      status_nxt = ST_NOT_TCP;
    end else begin
      status_nxt = ST_OK;
    end

    ip_cs_nxt  = ((status_nxt == ST_OK) || (status_nxt == ST_NOT_TCP)) ? ~snap.hdr_sum : '0;
    tcp_cs_nxt = (status_nxt == ST_OK) ? ~seg_final : '0;
  end

  assign free       = !out_valid_r || out_ready;
  assign snap_ready = free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && snap_valid) begin
      ip_cs_r  <= ip_cs_nxt;
      tcp_cs_r <= tcp_cs_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ip_checksum  = ip_cs_r;
  assign out_tcp_checksum = tcp_cs_r;
  assign out_status       = status_r;

endmodule

FILE: sv/tcp_ipv4_checksum_fill_unit.sv
// tcp_ipv4_checksum_fill_unit: top level of the ipv4 header / tcp checksum generator
// depends on tcf_pkg, tcf_ifs, tcf_accum and tcf_finish
//
// Takes an ipv4 packet one byte per transfer, last byte marked, and gives one
// result per packet: the complemented ip header checksum, the complemented tcp
// checksum over pseudo-header and segment, and a status (ok, not tcp, header
// length under five words, truncated). One byte is accepted every cycle while
// in_ready is high; the accumulators fold each byte in the cycle it arrives.
// The result passes through a snapshot register and then a result register,
// and input stalls only when both of those hold results that the sink has
// not taken.
module tcp_ipv4_checksum_fill_unit (
  input  logic      clk,
  input  logic      rst_n,
  tcf_in_if.sink    in_ch,
  tcf_out_if.source out_ch
);
  import tcf_pkg::*;

  logic  in_transfer;
  logic  in_ready;
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  assign in_ch.ready = in_ready;
  assign in_transfer = in_ch.valid && in_ready;

  tcf_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_transfer  (in_transfer),
    .in_pkt_byte  (in_ch.pkt_byte),
    .in_last_byte (in_ch.last_byte),
    .in_ready     (in_ready),
    .snap_ready   (snap_ready),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  tcf_finish u_finish (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .snap_ready       (snap_ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_ip_checksum  (out_ch.ip_checksum),
    .out_tcp_checksum (out_ch.tcp_checksum),
    .out_status       (out_ch.status)
  );

endmodule
